FILE: design/tsg_pkg.sv
// ----------------------------------------------------------------------------
// Triangle setup package
// Shared widths, pipeline stage indexes and payload types for the setup block.
// ----------------------------------------------------------------------------
`default_nettype none

package tsg_pkg;

  // Field widths.
  localparam int CW  = 17;  // edge delta, signed
  localparam int AW  = 35;  // signed area
  localparam int PW  = 26;  // delta times 8-bit channel value, signed
  localparam int NW  = 27;  // gradient numerator, signed
  localparam int OW  = 24;  // 12.12 result
  localparam int QW  = 25;  // divider quotient bits
  localparam int XW  = NW + 18;  // divider dividend 2|n|*65536 + |area|
  localparam int YW  = AW + 1;   // divider divisor 2|area|

  // Pipeline stage indexes.
  localparam int DIV_STEPS  = QW;
  localparam int ST_S1      = 0;  // edge deltas
  localparam int ST_S2      = 1;  // products
  localparam int ST_S3      = 2;  // area and numerators
  localparam int ST_PREP    = 3;  // divider operands
  localparam int ST_OUT     = ST_PREP + DIV_STEPS + 1;
  localparam int NUM_STAGES = ST_OUT + 1;

  // Saturation limits of a 12.12 result.
  localparam logic signed [OW-1:0] OUT_MAX = {1'b0, {(OW-1){1'b1}}};
  localparam logic signed [OW-1:0] OUT_MIN = {1'b1, {(OW-1){1'b0}}};

  // Input item as packed on tdata, last field in the lowest bits.
  typedef struct packed {
    logic [23:0]        colour_c;
    logic [23:0]        colour_b;
    logic [23:0]        colour_a;
    logic signed [15:0] cy;
    logic signed [15:0] cx;
    logic signed [15:0] by_coord;
    logic signed [15:0] bx;
    logic signed [15:0] ay;
    logic signed [15:0] ax;
  } in_item_t;

  // Edge deltas of one triangle.
  typedef struct packed {
    logic signed [CW-1:0] ex0;
    logic signed [CW-1:0] ex1;
    logic signed [CW-1:0] ex2;
    logic signed [CW-1:0] ey0;
    logic signed [CW-1:0] ey1;
    logic signed [CW-1:0] ey2;
  } delta_t;

endpackage

`default_nettype wire

FILE: design/triangle_setup_gradients.sv
// ----------------------------------------------------------------------------
// Triangle setup with Gouraud gradients
// Edge setup, signed area and per-channel colour gradients in 12.12.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one triangle per item: three 12.4 vertices and
//   an RGB888 colour per vertex. The master stream returns one item per
//   triangle: the start colour at vertex A and the x and y gradient of each
//   channel, with tuser set when the area is zero (all data is then zero).
//   Throughput is one item per cycle while the receiver keeps up; each
//   channel lane has two dividers pipelined at one quotient bit per stage.
//   Every stage holds its item until the next stage is free, so bubbles
//   close up and new items are taken while a result waits; when the
//   receiver stalls long enough the pipeline fills and tready drops.
//   Reset empties the pipeline; tready is high right after reset.
//   CHANNELS sets the number of colour lanes; fields of missing lanes are 0.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_setup_gradients #(
  parameter int CHANNELS = 3
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // ax, ay, bx, by_coord, cx, cy, colour_a, colour_b, colour_c
  input  wire logic [167:0] s_axis_tdata_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // start_red, start_green, start_blue, red_step_x, red_step_y,
  // green_step_x, green_step_y, blue_step_x, blue_step_y
  output logic [215:0]      m_axis_tdata_o,
  // degenerate
  output logic              m_axis_tuser_o
);
  import tsg_pkg::*;

  localparam int LANES = (CHANNELS < 3) ? CHANNELS : 3;

  logic [NUM_STAGES-1:0] v_q, en;
  logic [23:0]           ca_q   [ST_OUT];
  logic                  zero_q [ST_OUT];
  delta_t                delta;
  logic [23:0]           col_a, col_b, col_c;
  logic signed [AW-1:0]  area;
  logic signed [OW-1:0]  sx [3];
  logic signed [OW-1:0]  sy [3];
  logic [215:0]          out_d, out_q;
  logic                  degen_q;

  // Each stage moves on when it is empty or its successor moves on.
  always_comb begin
    en[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || m_axis_tready_i;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= s_axis_tvalid_i;
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  // Side pipeline: colour of vertex A and the zero-area flag.
  always_ff @(posedge clk_i) begin
    if (en[0]) ca_q[0] <= s_axis_tdata_i[119:96];
    for (int i = 1; i < ST_OUT; i++) begin
      if (en[i]) begin
        ca_q[i] <= ca_q[i-1];
        if (i == ST_PREP)     zero_q[i] <= (area == '0);
        else if (i > ST_PREP) zero_q[i] <= zero_q[i-1];
      end
    end
  end

  tsg_front u_front (
    .clk_i   (clk_i),
    .en_i    (en),
    .item_i  (in_item_t'(s_axis_tdata_i)),
    .delta_o (delta),
    .col_a_o (col_a),
    .col_b_o (col_b),
    .col_c_o (col_c),
    .area_o  (area)
  );

  // One lane per colour channel.
  for (genvar k = 0; k < 3; k++) begin : g_lane
    if (k < LANES) begin : g_on
      tsg_lane #(.K(k)) u_lane (
        .clk_i    (clk_i),
        .en_i     (en),
        .delta_i  (delta),
        .col_a_i  (col_a),
        .col_b_i  (col_b),
        .col_c_i  (col_c),
        .area_i   (area),
        .step_x_o (sx[k]),
        .step_y_o (sy[k])
      );
    end else begin : g_off
      assign sx[k] = '0;
      assign sy[k] = '0;
    end
  end

  // Merge the lanes into one result item. The start value is exact: va * 4096.
  always_comb begin
    out_d = '0;
    if (!zero_q[ST_OUT-1]) begin
      for (int k = 0; k < LANES; k++) begin
        out_d[24*k +: 24]      = {4'b0, ca_q[ST_OUT-1][16-8*k +: 8], 12'b0};
        out_d[72 + 48*k +: 24] = sx[k];
        out_d[96 + 48*k +: 24] = sy[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      out_q   <= out_d;
      degen_q <= zero_q[ST_OUT-1];
    end
  end

  assign s_axis_tready_o = en[0];
  assign m_axis_tvalid_o = v_q[ST_OUT];
  assign m_axis_tdata_o  = out_q;
  assign m_axis_tuser_o  = degen_q;

endmodule

`default_nettype wire

FILE: design/tsg_front.sv
// ----------------------------------------------------------------------------
// Triangle setup front end
// Forms the edge deltas, the two cross products and the signed area.
// ----------------------------------------------------------------------------
`default_nettype none

module tsg_front (
  input  wire logic                        clk_i,
  input  wire logic [tsg_pkg::NUM_STAGES-1:0] en_i,
  input  wire tsg_pkg::in_item_t           item_i,
  output tsg_pkg::delta_t                  delta_o,
  output logic [23:0]                      col_a_o,
  output logic [23:0]                      col_b_o,
  output logic [23:0]                      col_c_o,
  output logic signed [tsg_pkg::AW-1:0]    area_o
);
  import tsg_pkg::*;

  delta_t                      delta_q;
  logic [23:0]                 col_a_q, col_b_q, col_c_q;
  logic signed [2*CW-1:0]      p0_q, p1_q;
  logic signed [AW-1:0]        area_q;
  delta_t                      delta_d;

  // Edge deltas, sign extended by one bit.
  always_comb begin
    delta_d.ex0 = CW'(item_i.ax) - CW'(item_i.cx);
    delta_d.ex1 = CW'(item_i.bx) - CW'(item_i.ax);
    delta_d.ex2 = CW'(item_i.cx) - CW'(item_i.bx);
    delta_d.ey0 = CW'(item_i.ay) - CW'(item_i.cy);
    delta_d.ey1 = CW'(item_i.by_coord) - CW'(item_i.ay);
    delta_d.ey2 = CW'(item_i.cy) - CW'(item_i.by_coord);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_S1]) begin
      delta_q <= delta_d;
      col_a_q <= item_i.colour_a;
      col_b_q <= item_i.colour_b;
      col_c_q <= item_i.colour_c;
    end
  end

  // Only the edge through B and C is nonzero at vertex A, so it equals the area.
  always_ff @(posedge clk_i) begin
    if (en_i[ST_S2]) begin
      p0_q <= delta_q.ex0 * delta_q.ey2;
      p1_q <= delta_q.ey0 * delta_q.ex2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_S3]) begin
      area_q <= AW'(p0_q) - AW'(p1_q);
    end
  end

  assign delta_o = delta_q;
  assign col_a_o = col_a_q;
  assign col_b_o = col_b_q;
  assign col_c_o = col_c_q;
  assign area_o  = area_q;

endmodule

`default_nettype wire

FILE: design/tsg_div.sv
// ----------------------------------------------------------------------------
// Triangle setup divider
// Pipelined restoring divider, one quotient bit per stage, rounding to
// nearest with ties away from zero and saturating to 12.12.
// ----------------------------------------------------------------------------
`default_nettype none

module tsg_div (
  input  wire logic                            clk_i,
  input  wire logic [tsg_pkg::DIV_STEPS:0]     en_i,
  input  wire logic signed [tsg_pkg::NW-1:0]   num_i,
  input  wire logic signed [tsg_pkg::AW-1:0]   area_i,
  output logic signed [tsg_pkg::OW-1:0]        res_o
);
  import tsg_pkg::*;

  logic [XW-1:0] r_q [DIV_STEPS+1];
  logic [YW-1:0] y_q [DIV_STEPS+1];
  logic [QW-1:0] q_q [DIV_STEPS+1];
  logic          ovf_q [DIV_STEPS+1];
  logic          neg_q [DIV_STEPS+1];
  logic [XW-1:0] r_d [DIV_STEPS+1];
  logic [YW-1:0] y_d [DIV_STEPS+1];
  logic [QW-1:0] q_d [DIV_STEPS+1];
  logic          ovf_d [DIV_STEPS+1];
  logic          neg_d [DIV_STEPS+1];

  always_comb begin
    logic [NW-1:0] abs_n;
    logic [AW-1:0] abs_d;
    logic [63:0]   ysh;
    // Operand setup: (2|n|*65536 + |d|) / (2|d|), quotient must stay below 2^25.
    abs_n    = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
    abs_d    = area_i[AW-1] ? AW'(-area_i) : AW'(area_i);
    r_d[0]   = {1'b0, abs_n, 17'b0} + XW'(abs_d);
    y_d[0]   = {abs_d, 1'b0};
    q_d[0]   = '0;
    ysh      = 64'(y_d[0]) << QW;
    ovf_d[0] = 64'(r_d[0]) >= ysh;
    neg_d[0] = num_i[NW-1] ^ area_i[AW-1];
    // One quotient bit per stage, most significant first.
    for (int j = 1; j <= DIV_STEPS; j++) begin
      ysh      = 64'(y_q[j-1]) << (DIV_STEPS - j);
      y_d[j]   = y_q[j-1];
      ovf_d[j] = ovf_q[j-1];
      neg_d[j] = neg_q[j-1];
      if (64'(r_q[j-1]) >= ysh) begin
        r_d[j] = r_q[j-1] - ysh[XW-1:0];
        q_d[j] = q_q[j-1] | (QW'(1) << (DIV_STEPS - j));
      end else begin
        r_d[j] = r_q[j-1];
        q_d[j] = q_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j <= DIV_STEPS; j++) begin
      if (en_i[j]) begin
        r_q[j]   <= r_d[j];
        y_q[j]   <= y_d[j];
        q_q[j]   <= q_d[j];
        ovf_q[j] <= ovf_d[j];
        neg_q[j] <= neg_d[j];
      end
    end
  end

  // Apply the sign and saturate.
  always_comb begin
    logic [QW-1:0] q;
    q = q_q[DIV_STEPS];
    if (ovf_q[DIV_STEPS]) begin
      res_o = neg_q[DIV_STEPS] ? OUT_MIN : OUT_MAX;
    end else if (neg_q[DIV_STEPS]) begin
      if (q > QW'(1) << (OW - 1)) res_o = OUT_MIN;
      else                         res_o = OW'(-q);
    end else begin
      if (q > QW'(OUT_MAX)) res_o = OUT_MAX;
      else                  res_o = OW'(q);
    end
  end

endmodule

`default_nettype wire

FILE: design/tsg_lane.sv
// ----------------------------------------------------------------------------
// Triangle setup colour lane
// Gradient numerators of one colour channel and its two dividers.
// ----------------------------------------------------------------------------
`default_nettype none

module tsg_lane #(
  parameter int K = 0
) (
  input  wire logic                             clk_i,
  input  wire logic [tsg_pkg::NUM_STAGES-1:0]   en_i,
  input  wire tsg_pkg::delta_t                  delta_i,
  input  wire logic [23:0]                      col_a_i,
  input  wire logic [23:0]                      col_b_i,
  input  wire logic [23:0]                      col_c_i,
  input  wire logic signed [tsg_pkg::AW-1:0]    area_i,
  output logic signed [tsg_pkg::OW-1:0]         step_x_o,
  output logic signed [tsg_pkg::OW-1:0]         step_y_o
);
  import tsg_pkg::*;

  localparam int LSB = 16 - 8 * K;

  logic signed [8:0]    va, vb, vc;
  logic signed [PW-1:0] px0_q, px1_q, px2_q, py0_q, py1_q, py2_q;
  logic signed [NW-1:0] nx_q, ny_q;

  assign va = $signed({1'b0, col_a_i[LSB +: 8]});
  assign vb = $signed({1'b0, col_b_i[LSB +: 8]});
  assign vc = $signed({1'b0, col_c_i[LSB +: 8]});

  // Deltas weighted by the colour of the opposite vertex.
  always_ff @(posedge clk_i) begin
    if (en_i[ST_S2]) begin
      px0_q <= PW'(delta_i.ey0 * vb);
      px1_q <= PW'(delta_i.ey1 * vc);
      px2_q <= PW'(delta_i.ey2 * va);
      py0_q <= PW'(delta_i.ex0 * vb);
      py1_q <= PW'(delta_i.ex1 * vc);
      py2_q <= PW'(delta_i.ex2 * va);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_S3]) begin
      nx_q <= NW'(px0_q) + NW'(px1_q) + NW'(px2_q);
      ny_q <= -(NW'(py0_q) + NW'(py1_q) + NW'(py2_q));
    end
  end

  tsg_div u_div_x (
    .clk_i  (clk_i),
    .en_i   (en_i[ST_PREP +: DIV_STEPS + 1]),
    .num_i  (nx_q),
    .area_i (area_i),
    .res_o  (step_x_o)
  );

  tsg_div u_div_y (
    .clk_i  (clk_i),
    .en_i   (en_i[ST_PREP +: DIV_STEPS + 1]),
    .num_i  (ny_q),
    .area_i (area_i),
    .res_o  (step_y_o)
  );

endmodule

`default_nettype wire

FILE: design/tsg_checker.sv
// ----------------------------------------------------------------------------
// Triangle setup checker
// Port-level assertions on the input and result streams, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tsg_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tready_i,
  input wire logic         m_axis_tvalid_i,
  input wire logic         m_axis_tready_i,
  input wire logic [215:0] m_axis_tdata_i,
  input wire logic         m_axis_tuser_i
);

  // A stalled result item stays offered.
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i)
    else $error("result item dropped while stalled");

  // A degenerate triangle carries all-zero data.
  a_degen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && m_axis_tuser_i |-> m_axis_tdata_i == '0)
    else $error("degenerate item with nonzero data");

  // The red start value is a whole 8-bit level in 12.12.
  a_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> m_axis_tdata_i[11:0] == '0 && m_axis_tdata_i[23:20] == '0)
    else $error("start value is not a whole level");

  // With no result waiting the pipeline can always take an item.
  a_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_i |-> s_axis_tready_i)
    else $error("input stalled while output is empty");

endmodule

bind triangle_setup_gradients tsg_checker u_tsg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_i (s_axis_tready_o),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o)
);

`default_nettype wire

FILE: tb/sv/tb_triangle_setup_gradients.sv
// ----------------------------------------------------------------------------
// Triangle setup testbench
// Drives triangles through the slave stream with bursty valid and a stalling
// receiver, predicts start colours and gradients with exact integer math,
// and checks each result item field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_triangle_setup_gradients;
  import tsg_pkg::*;

  localparam int NUM_CH   = 3;
  localparam int LATENCY  = 31;
  localparam int N_RANDOM = 1500;
  localparam logic signed [63:0] SAT_HI = 64'sd8388607;
  localparam logic signed [63:0] SAT_LO = -64'sd8388608;

  typedef struct packed {
    logic         degenerate;
    logic [215:0] data;
  } setup_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [167:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [215:0] m_axis_tdata_o;
  logic         m_axis_tuser_o;

  setup_t expected_setups[$];
  int     error_count = 0;
  bit     sending_done = 1'b0;

  triangle_setup_gradients #(.CHANNELS(NUM_CH)) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  // Rounds n/d to nearest with ties away from zero, then saturates to 24 bits.
  function automatic logic [23:0] round_sat(input logic signed [63:0] n,
                                            input logic signed [63:0] d);
    logic [63:0]        un, ud, q;
    logic signed [63:0] v;
    un = n < 0 ? -n : n;
    ud = d < 0 ? -d : d;
    q  = (2 * un + ud) / (2 * ud);
    v  = ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
    if (v > SAT_HI) v = SAT_HI;
    if (v < SAT_LO) v = SAT_LO;
    return v[23:0];
  endfunction

  // Computes the setup result of one triangle.
  function automatic setup_t triangle_setup(input in_item_t t);
    setup_t             r;
    logic signed [63:0] x0, y0, x1, y1, x2, y2;
    logic signed [63:0] ex0, ex1, ex2, ey0, ey1, ey2, f1, f2, area;
    logic signed [63:0] va, vb, vc, nx, ny, ns;
    x0 = t.ax; y0 = t.ay; x1 = t.bx; y1 = t.by_coord; x2 = t.cx; y2 = t.cy;
    ex0 = x0 - x2; ex1 = x1 - x0; ex2 = x2 - x1;
    ey0 = y0 - y2; ey1 = y1 - y0; ey2 = y2 - y1;
    f1 = (x0 - x1) * ey1 - (y0 - y1) * ex1;
    f2 = (x0 - x2) * ey2 - (y0 - y2) * ex2;
    area = f1 + f2;
    r = '0;
    if (area == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    for (int k = 0; k < NUM_CH && k < 3; k++) begin
      va = t.colour_a[16-8*k +: 8];
      vb = t.colour_b[16-8*k +: 8];
      vc = t.colour_c[16-8*k +: 8];
      nx = ey0 * vb + ey1 * vc + ey2 * va;
      ny = -(ex0 * vb + ex1 * vc + ex2 * va);
      ns = f1 * vc + f2 * va;
      r.data[24*k +: 24]       = round_sat(ns * 4096, area);
      r.data[24*(3+2*k) +: 24] = round_sat(nx * 65536, area);
      r.data[24*(4+2*k) +: 24] = round_sat(ny * 65536, area);
    end
    return r;
  endfunction

  function automatic in_item_t make_triangle(input int x0, y0, x1, y1, x2, y2,
                                             input logic [23:0] ca, cb, cc);
    in_item_t t;
    t.ax = 16'(x0); t.ay = 16'(y0); t.bx = 16'(x1);
    t.by_coord = 16'(y1); t.cx = 16'(x2); t.cy = 16'(y2);
    t.colour_a = ca; t.colour_b = cb; t.colour_c = cc;
    return t;
  endfunction

  // Mostly small, well-formed triangles; some full-range vertices.
  function automatic in_item_t random_triangle();
    in_item_t t;
    int       base_x, base_y, span;
    t = 168'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    if ($urandom_range(0, 9) < 7) begin
      span   = $urandom_range(0, 3) == 0 ? 32767 : (1 << $urandom_range(2, 12));
      base_x = $signed(16'($urandom));
      base_y = $signed(16'($urandom));
      t.ax = 16'(base_x); t.ay = 16'(base_y);
      t.bx = 16'(base_x + $urandom_range(0, 2 * span) - span);
      t.by_coord = 16'(base_y + $urandom_range(0, 2 * span) - span);
      t.cx = 16'(base_x + $urandom_range(0, 2 * span) - span);
      t.cy = 16'(base_y + $urandom_range(0, 2 * span) - span);
    end else if ($urandom_range(0, 9) == 0) begin
      // Collinear vertices give a zero area.
      t.bx = t.ax; t.by_coord = t.ay;
    end
    return t;
  endfunction

  // Sends one item, honoring bursts: random gaps before some items.
  task automatic send_item(input in_item_t t, input setup_t ref_result,
                           input bit use_ref);
    if ($urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= t;
    expected_setups.push_back(use_ref ? ref_result : triangle_setup(t));
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // Stimulus: directed table, then random triangles.
  initial begin
    in_item_t directed_tris[$];
    setup_t   directed_refs[$];
    bit       directed_typed[$];
    setup_t   zero_result;
    zero_result = '0;
    zero_result.degenerate = 1'b1;
    // Rows with a typed-in result: all-zero, coincident or collinear vertices give zero area.
    directed_tris.push_back(make_triangle(0, 0, 0, 0, 0, 0, 24'h0, 24'h0, 24'h0));
    directed_refs.push_back(zero_result); directed_typed.push_back(1);
    directed_tris.push_back(make_triangle(-32768, 32767, -32768, 32767, -32768, 32767,
                                          24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
    directed_refs.push_back(zero_result); directed_typed.push_back(1);
    directed_tris.push_back(make_triangle(0, 0, 16, 16, 32, 32,
                                          24'h123456, 24'hABCDEF, 24'hFFFFFF));
    directed_refs.push_back(zero_result); directed_typed.push_back(1);
    // Predicted rows: unit and huge triangles, both windings, colour extremes.
    directed_tris.push_back(make_triangle(0, 0, 16, 0, 0, 16,
                                          24'hFFFFFF, 24'h000000, 24'h000000));
    directed_tris.push_back(make_triangle(0, 0, 0, 16, 16, 0,
                                          24'h000000, 24'hFFFFFF, 24'hFF00FF));
    directed_tris.push_back(make_triangle(-32768, -32768, 32767, -32768, -32768, 32767,
                                          24'hFFFFFF, 24'h000000, 24'h80FF01));
    directed_tris.push_back(make_triangle(32767, 32767, -32768, 32767, 32767, -32768,
                                          24'h000000, 24'hFFFFFF, 24'hFFFFFF));
    directed_tris.push_back(make_triangle(0, 0, 1, 0, 0, 1,
                                          24'h000000, 24'hFFFFFF, 24'hFFFFFF));
    directed_tris.push_back(make_triangle(0, 0, 1, 0, 0, 1,
                                          24'hFFFFFF, 24'h000000, 24'h000000));
    directed_tris.push_back(make_triangle(100, -50, 101, 3000, -7000, 12,
                                          24'h7F8001, 24'hFE01AA, 24'h55AA55));
    directed_tris.push_back(make_triangle(-1, -1, 2, -1, -1, 1,
                                          24'h010101, 24'h020202, 24'h030303));
    for (int i = 3; i < directed_tris.size(); i++) begin
      directed_refs.push_back('0); directed_typed.push_back(0);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_tris[i])
      send_item(directed_tris[i], directed_refs[i], directed_typed[i]);

    for (int n = 0; n < N_RANDOM; n++) begin
      // Drain the pipeline completely once mid-run.
      if (n == N_RANDOM / 2) begin
        s_axis_tvalid_i <= 1'b0;
        @(posedge clk_i);
        while (expected_setups.size() != 0) @(posedge clk_i);
      end
      send_item(random_triangle(), '0, 0);
    end
    s_axis_tvalid_i <= 1'b0;
    sending_done = 1'b1;
  end

  // Receiver: mixes fully open stretches with phases of light and heavy random stalls.
  initial begin
    int mode;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(20, 120)) begin
        @(posedge clk_i);
        case (mode)
          0: m_axis_tready_i <= 1'b1;
          1: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready_i <= ($urandom_range(0, 9) < 2);
        endcase
      end
    end
  end

  // Checks each accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    setup_t exp_r;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_setups.size() == 0) begin
        $display("%0t: unexpected result data=%h user=%b", $time,
                 m_axis_tdata_o, m_axis_tuser_o);
        error_count++;
      end else begin
        exp_r = expected_setups.pop_front();
        if (m_axis_tuser_o !== exp_r.degenerate) begin
          $display("%0t: degenerate expected %b actual %b", $time,
                   exp_r.degenerate, m_axis_tuser_o);
          error_count++;
        end
        for (int f = 0; f < 9; f++)
          if (m_axis_tdata_o[24*f +: 24] !== exp_r.data[24*f +: 24]) begin
            $display("%0t: field %0d expected %h actual %h", $time, f,
                     exp_r.data[24*f +: 24], m_axis_tdata_o[24*f +: 24]);
            error_count++;
          end
      end
    end
  end

  // End of run: wait for all results, then report the verdict.
  initial begin
    wait (sending_done);
    while (expected_setups.size() != 0) @(posedge clk_i);
    repeat (4 * LATENCY) @(posedge clk_i);
    if (error_count == 0 && expected_setups.size() == 0)
      $display("** triangle_setup_gradients: PASSED **");
    else
      $display("** triangle_setup_gradients: FAILED **");
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("timeout");
    $display("** triangle_setup_gradients: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
